// ===== hw/rtl/csg_pkg.sv =====
// ----------------------------------------------------------------------------
// csg_pkg
// Types, constants and helper functions for the cylinder sector point
// generator.
// ----------------------------------------------------------------------------
package csg_pkg;

	localparam int CORDIC_STAGES_DEF = 18;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_END_ANGLE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_AXIAL_HEIGHT = 3'd7;

	localparam logic [16:0] FRAC_ONE = 17'd65536;
	localparam logic signed [29:0] DEG360 = 30'sd23592960;
	localparam logic signed [29:0] DEG270 = 30'sd17694720;
	localparam logic signed [29:0] DEG180 = 30'sd11796480;
	localparam logic signed [29:0] DEG90 = 30'sd5898240;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
	localparam logic [63:0] KDEG_Q24 = 64'd961263669;

	localparam logic [31:0] ATAN_HEAD [14] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
		32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
		32'd938734, 32'd469367, 32'd234684, 32'd117342
	};

	typedef struct packed {
		logic [16:0] angle_fraction;
		logic [16:0] radial_fraction;
		logic [16:0] axial_fraction;
	} csg_in_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} csg_out_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic [30:0] inner_radius;
		logic [30:0] outer_radius;
		logic signed [26:0] start_angle;
		logic signed [26:0] end_angle;
		logic signed [31:0] axial_height;
	} csg_cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic neg;
		logic signed [31:0] radius;
		logic signed [31:0] pz;
	} csg_rot_t;

	function automatic logic [31:0] csg_atan(input int i);
		logic [63:0] v;
		v = 64'd0;
		if (i < 14) begin
			return ATAN_HEAD[i];
		end
		v = (KDEG_Q24 + (64'd1 << (i - 1))) >> i;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] csg_sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (v < -34'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [16:0] csg_frac(input logic [16:0] v);
		return (v > FRAC_ONE) ? FRAC_ONE : v;
	endfunction

endpackage

// ===== hw/rtl/cylinder_sector_point_generator_top.sv =====
// ----------------------------------------------------------------------------
// cylinder_sector_point_generator_top
// Maps angular, radial and axial fractions to Cartesian points on a
// cylinder sector.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall/in_data) carry three Q1.16 fractions; output
// beats (out_valid/out_stall/out_data) carry point_x, point_y, point_z in
// Q16.16. Configuration registers are written through cfg_we/cfg_index/
// cfg_data; the user must do so only while no beat is in flight, as the
// block does not enforce it. There are three front stages (products,
// interpolation, angle reduction), one per CORDIC iteration, one multiply
// stage and output register. One beat is accepted every cycle unless stalled.
// When out_valid is high and out_stall is asserted the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears every valid bit and loads the register defaults: origin 0,
// radii 0 and 1.0, angles 0 and 360 degrees, height 1.0.
// ----------------------------------------------------------------------------
module cylinder_sector_point_generator_top #(
	parameter int CORDIC_STAGES = csg_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  csg_pkg::csg_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output csg_pkg::csg_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [csg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import csg_pkg::*;

	csg_cfg_t cfg_q;
	logic     en;
	logic     vld [CORDIC_STAGES+1];
	csg_rot_t rot [CORDIC_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= 32'sd0;
			cfg_q.origin_y <= 32'sd0;
			cfg_q.origin_z <= 32'sd0;
			cfg_q.inner_radius <= 31'd0;
			cfg_q.outer_radius <= 31'd65536;
			cfg_q.start_angle <= 27'sd0;
			cfg_q.end_angle <= 27'sd23592960;
			cfg_q.axial_height <= 32'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				REG_ORIGIN_Z: cfg_q.origin_z <= cfg_data;
				REG_INNER_RADIUS: cfg_q.inner_radius <= cfg_data[30:0];
				REG_OUTER_RADIUS: cfg_q.outer_radius <= cfg_data[30:0];
				REG_START_ANGLE: cfg_q.start_angle <= cfg_data[26:0];
				REG_END_ANGLE: cfg_q.end_angle <= cfg_data[26:0];
				REG_AXIAL_HEIGHT: cfg_q.axial_height <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	csg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.out_valid(vld[0]),
		.out_data (rot[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		csg_cordic_stage #(.IDX(i)) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (vld[i]),
			.in_data  (rot[i]),
			.out_valid(vld[i+1]),
			.out_data (rot[i+1])
		);
	end

	csg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld[CORDIC_STAGES]),
		.in_data  (rot[CORDIC_STAGES]),
		.cfg      (cfg_q),
		.out_valid(out_valid),
		.out_data (out_data)
	);

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output beat");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (out_valid && $stable(vld[0])))
		else $error("pipeline moved during a stall");

endmodule

// ===== hw/rtl/csg_front.sv =====
// ----------------------------------------------------------------------------
// csg_front
// Interpolation of angle, radius and z, angle reduction and quadrant fold.
// ----------------------------------------------------------------------------
module csg_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  csg_pkg::csg_in_t  in_data,
	input  csg_pkg::csg_cfg_t cfg,
	output logic              out_valid,
	output csg_pkg::csg_rot_t out_data
);
	import csg_pkg::*;

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [45:0] aprod_s1;
	logic signed [49:0] rprod_s1, zprod_s1;
	logic signed [27:0] ang_s2;
	logic signed [31:0] radius_s2, pz_s2;
	csg_rot_t           rot_s3;

	logic signed [27:0] adiff;
	logic signed [31:0] rdiff;
	logic signed [33:0] zsum;
	logic signed [29:0] av, red, cand, fold;
	logic               neg;

	assign adiff = 28'(cfg.end_angle) - 28'(cfg.start_angle);
	assign rdiff = $signed({1'b0, cfg.outer_radius}) - $signed({1'b0, cfg.inner_radius});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign zsum = 34'(cfg.origin_z) + 34'((zprod_s1 + 50'sd32768) >>> 16);

	always_comb begin
		av = 30'(ang_s2);
		red = av;
		for (int k = -2; k <= 3; k++) begin
			cand = av + 30'(k) * DEG360;
			if (cand >= 30'sd0 && cand < DEG360) begin
				red = cand;
			end
		end
		neg = 1'b0;
		fold = red;
		if (red > DEG90 && red < DEG270) begin
			fold = red - DEG180;
			neg = 1'b1;
		end else if (red >= DEG270) begin
			fold = red - DEG360;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aprod_s1 <= adiff * $signed({1'b0, csg_frac(in_data.angle_fraction)});
			rprod_s1 <= rdiff * $signed({1'b0, csg_frac(in_data.radial_fraction)});
			zprod_s1 <= cfg.axial_height * $signed({1'b0, csg_frac(in_data.axial_fraction)});
			ang_s2 <= 28'(cfg.start_angle) + 28'((aprod_s1 + 46'sd32768) >>> 16);
			radius_s2 <= $signed({1'b0, cfg.inner_radius})
				+ 32'((rprod_s1 + 50'sd32768) >>> 16);
			pz_s2 <= csg_sat32(zsum);
			rot_s3.x <= GAIN_Q30;
			rot_s3.y <= 32'sd0;
			rot_s3.z <= 32'(fold) <<< 8;
			rot_s3.neg <= neg;
			rot_s3.radius <= radius_s2;
			rot_s3.pz <= pz_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_data = rot_s3;

endmodule

// ===== hw/rtl/csg_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// csg_cordic_stage
// One rotation-mode CORDIC iteration with its pipeline register.
// ----------------------------------------------------------------------------
module csg_cordic_stage #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  csg_pkg::csg_rot_t in_data,
	output logic              out_valid,
	output csg_pkg::csg_rot_t out_data
);
	import csg_pkg::*;

	localparam logic signed [31:0] ATAN = $signed(csg_atan(IDX));

	logic     valid_s1;
	csg_rot_t rot_s1;
	csg_rot_t nxt;
	logic signed [31:0] dx, dy;

	assign dx = in_data.y >>> IDX;
	assign dy = in_data.x >>> IDX;

	always_comb begin
		nxt = in_data;
		if (in_data.z >= 32'sd0) begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - ATAN;
		end else begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data = rot_s1;

endmodule

// ===== hw/rtl/csg_back.sv =====
// ----------------------------------------------------------------------------
// csg_back
// Radius scaling, origin offset, saturation and output register.
// ----------------------------------------------------------------------------
module csg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  csg_pkg::csg_rot_t in_data,
	input  csg_pkg::csg_cfg_t cfg,
	output logic              out_valid,
	output csg_pkg::csg_out_t out_data
);
	import csg_pkg::*;

	logic               valid_s1, valid_s2;
	logic signed [63:0] px_s1, py_s1;
	logic signed [31:0] pz_s1;
	csg_out_t           res_s2;
	logic signed [31:0] cx, cy;

	assign cx = in_data.neg ? -in_data.x : in_data.x;
	assign cy = in_data.neg ? -in_data.y : in_data.y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= in_data.radius * cx;
			py_s1 <= in_data.radius * cy;
			pz_s1 <= in_data.pz;
			res_s2.point_x <= csg_sat32(34'(cfg.origin_x)
				+ 34'((px_s1 + 64'sd536870912) >>> 30));
			res_s2.point_y <= csg_sat32(34'(cfg.origin_y)
				+ 34'((py_s1 + 64'sd536870912) >>> 30));
			res_s2.point_z <= pz_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = res_s2;

endmodule
